[src/psd_pkg.sv]
// Shared types, codes and arithmetic helpers of the polygon stream decoder.
package psd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_PALETTE = 3'd0;
    localparam logic [2:0] KIND_TRIANGLE = 3'd1;
    localparam logic [2:0] KIND_CLEAR = 3'd2;
    localparam logic [2:0] KIND_FRAME_END = 3'd3;
    localparam logic [2:0] KIND_STREAM_END = 3'd4;

    localparam logic [7:0] DESC_FRAME_END = 8'hff;
    localparam logic [7:0] DESC_FRAME_SKIP = 8'hfe;
    localparam logic [7:0] DESC_STREAM_END = 8'hfd;

    typedef enum logic [3:0] {
        PH_FLAGS, PH_MASK_HI, PH_MASK_LO, PH_COL_HI, PH_COL_LO, PH_VCOUNT,
        PH_VX, PH_VY, PH_DESC, PH_PIDX, PH_PX, PH_PY, PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {BK_IDLE, BK_CLEAR, BK_VREAD, BK_FAN} t_bstate;

    typedef enum logic [2:0] {
        CMD_PAL, CMD_CLEAR, CMD_FEND, CMD_SEND, CMD_VWR, CMD_PVTX
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic        clear_after;
        logic [3:0]  color;
        logic [2:0]  red;
        logic [2:0]  green;
        logic [2:0]  blue;
        logic        indexed;
        logic [7:0]  addr;
        logic [7:0]  slot;
        logic [8:0]  x;
        logic [8:0]  y;
        logic        poly_end;
        logic [3:0]  count;
    } t_cmd;

    // x * 125 / 100 is exactly floor(5x / 4).
    function automatic logic [8:0] scale_x(input logic [7:0] raw);
        logic [10:0] t;
        t = ({3'b0, raw} << 2) + {3'b0, raw};
        return t[10:2];
    endfunction

    // y * 120 / 100 is floor(6y / 5); the division by five uses a reciprocal
    // that is exact for all products below 2048.
    function automatic logic [8:0] scale_y(input logic [7:0] raw);
        logic [10:0] n;
        logic [21:0] p;
        n = ({3'b0, raw} << 2) + ({3'b0, raw} << 1);
        p = {11'b0, n} * 22'd1639;
        return p[21:13];
    endfunction

    function automatic logic [7:0] times36(input logic [2:0] c);
        return {c, 5'b0} + {3'b0, c, 2'b0};
    endfunction

    function automatic logic [3:0] top_bit(input logic [15:0] mask);
        logic [3:0] r;
        r = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (mask[b]) r = 4'(b);
        end
        return r;
    endfunction

endpackage

[src/psd_byte_if.sv]
// Handshake channel carrying one stream byte per beat.
interface psd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    modport source(output valid, output stream_byte, input ready);
    modport sink(input valid, input stream_byte, output ready);
endinterface

[src/psd_result_if.sv]
// Handshake channel carrying one decoded result per beat.
interface psd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] ax;
    logic [8:0] ay;
    logic [8:0] bx;
    logic [8:0] by;
    logic [8:0] cx;
    logic [8:0] cy;
    logic       last;
    modport source(output valid, output kind, output color_index, output red,
                   output green, output blue, output ax, output ay, output bx,
                   output by, output cx, output cy, output last, input ready);
    modport sink(input valid, input kind, input color_index, input red,
                 input green, input blue, input ax, input ay, input bx,
                 input by, input cx, input cy, input last, output ready);
endinterface

[src/psd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module psd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/psd_queue.sv]
// Short command queue between the parser and the executing back end.
module psd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output psd_pkg::t_cmd o_cmd
);
    import psd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_slots [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [PW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop) r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
        if (i_push) r_slots[r_wptr] <= i_cmd;
    end

    assign o_full = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd = r_slots[r_rptr];
endmodule

[src/psd_front.sv]
// Byte parser: tracks the stream syntax and turns bytes into back-end commands.
module psd_front #(
    parameter int SKIP_ALIGN_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psd_byte_if.sink      i_in,
    input  logic          i_full,
    output logic          o_push,
    output psd_pkg::t_cmd o_cmd
);
    import psd_pkg::*;

    t_phase                     r_phase, n_phase;
    logic [2:0]                 r_flags, n_flags;
    logic [15:0]                r_mask, n_mask;
    logic [7:0]                 r_hi, n_hi;
    logic [7:0]                 r_total, n_total;
    logic [7:0]                 r_cnt, n_cnt;
    logic [7:0]                 r_rawx, n_rawx;
    logic [3:0]                 r_pcount, n_pcount;
    logic [3:0]                 r_pcolor, n_pcolor;
    logic [SKIP_ALIGN_BITS-1:0] r_pos, n_pos, pos_inc;

    logic        accept;
    logic [7:0]  b, cnt_inc;
    logic [15:0] new_mask, mask_after;
    logic [3:0]  top;
    logic        poly_end;

    assign i_in.ready = !i_full;
    assign accept = i_in.valid && !i_full;
    assign b = i_in.stream_byte;
    assign pos_inc = r_pos + 1'b1;
    assign cnt_inc = r_cnt + 8'd1;
    assign new_mask = {r_hi, b};
    assign top = top_bit(r_mask);
    assign mask_after = r_mask & ~(16'd1 << top);
    assign poly_end = (cnt_inc >= {4'b0, r_pcount});

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_FLAGS:   n_phase = b[1] ? PH_MASK_HI : (b[2] ? PH_VCOUNT : PH_DESC);
                PH_MASK_HI: n_phase = PH_MASK_LO;
                PH_MASK_LO: n_phase = (new_mask != '0) ? PH_COL_HI
                                    : (r_flags[2] ? PH_VCOUNT : PH_DESC);
                PH_COL_HI:  n_phase = PH_COL_LO;
                PH_COL_LO:  n_phase = (mask_after != '0) ? PH_COL_HI
                                    : (r_flags[2] ? PH_VCOUNT : PH_DESC);
                PH_VCOUNT:  n_phase = (b != '0) ? PH_VX : PH_DESC;
                PH_VX:      n_phase = PH_VY;
                PH_VY:      n_phase = (cnt_inc >= r_total) ? PH_DESC : PH_VX;
                PH_DESC: begin
                    if (b == DESC_FRAME_END || b == DESC_STREAM_END) begin
                        n_phase = PH_FLAGS;
                    end else if (b == DESC_FRAME_SKIP) begin
                        n_phase = (pos_inc != '0) ? PH_SKIP : PH_FLAGS;
                    end else if (b[3:0] != '0) begin
                        n_phase = r_flags[2] ? PH_PIDX : PH_PX;
                    end
                end
                PH_PIDX:    n_phase = poly_end ? PH_DESC : PH_PIDX;
                PH_PX:      n_phase = PH_PY;
                PH_PY:      n_phase = poly_end ? PH_DESC : PH_PX;
                PH_SKIP:    n_phase = (pos_inc == '0) ? PH_FLAGS : PH_SKIP;
                default:    n_phase = PH_FLAGS;
            endcase
        end
    end

    always_comb begin
        n_flags = r_flags;
        n_mask = r_mask;
        n_hi = r_hi;
        n_total = r_total;
        n_cnt = r_cnt;
        n_rawx = r_rawx;
        n_pcount = r_pcount;
        n_pcolor = r_pcolor;
        n_pos = accept ? pos_inc : r_pos;
        o_push = 1'b0;
        o_cmd = '0;
        o_cmd.color = r_pcolor;
        o_cmd.count = r_pcount;
        o_cmd.slot = r_cnt;
        o_cmd.poly_end = poly_end;
        if (accept) begin
            case (r_phase)
                PH_FLAGS: begin
                    n_flags = b[2:0];
                    if (!b[1] && b[0]) begin
                        o_push = 1'b1;
                        o_cmd.op = CMD_CLEAR;
                    end
                end
                PH_MASK_HI, PH_COL_HI: n_hi = b;
                PH_MASK_LO: begin
                    n_mask = new_mask;
                    if (new_mask == '0 && r_flags[0]) begin
                        o_push = 1'b1;
                        o_cmd.op = CMD_CLEAR;
                    end
                end
                PH_COL_LO: begin
                    n_mask = mask_after;
                    o_push = 1'b1;
                    o_cmd.op = CMD_PAL;
                    o_cmd.color = 4'd15 - top;
                    o_cmd.red = r_hi[2:0];
                    o_cmd.green = b[6:4];
                    o_cmd.blue = b[2:0];
                    o_cmd.clear_after = (mask_after == '0) && r_flags[0];
                end
                PH_VCOUNT: begin
                    n_total = b;
                    n_cnt = '0;
                end
                PH_VX, PH_PX: n_rawx = b;
                PH_VY: begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_VWR;
                    o_cmd.addr = r_cnt;
                    o_cmd.x = scale_x(r_rawx);
                    o_cmd.y = scale_y(b);
                    n_cnt = cnt_inc;
                end
                PH_DESC: begin
                    if (b == DESC_FRAME_END || b == DESC_FRAME_SKIP) begin
                        o_push = 1'b1;
                        o_cmd.op = CMD_FEND;
                    end else if (b == DESC_STREAM_END) begin
                        o_push = 1'b1;
                        o_cmd.op = CMD_SEND;
                        n_pos = '0;
                    end else begin
                        n_pcount = b[3:0];
                        n_pcolor = b[7:4];
                        n_cnt = '0;
                    end
                end
                PH_PIDX: begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_PVTX;
                    o_cmd.indexed = 1'b1;
                    o_cmd.addr = b;
                    n_cnt = cnt_inc;
                end
                PH_PY: begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_PVTX;
                    o_cmd.x = scale_x(r_rawx);
                    o_cmd.y = scale_y(b);
                    n_cnt = cnt_inc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS;
            r_flags <= '0;
            r_mask <= '0;
            r_hi <= '0;
            r_total <= '0;
            r_cnt <= '0;
            r_rawx <= '0;
            r_pcount <= '0;
            r_pcolor <= '0;
            r_pos <= '0;
        end else begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_mask <= n_mask;
            r_hi <= n_hi;
            r_total <= n_total;
            r_cnt <= n_cnt;
            r_rawx <= n_rawx;
            r_pcount <= n_pcount;
            r_pcolor <= n_pcolor;
            r_pos <= n_pos;
        end
    end
endmodule

[src/psd_back.sv]
// Back end: owns the vertex store and polygon buffer and emits results.
module psd_back #(
    parameter int VERTEX_DEPTH = 256,
    parameter int POLY_MAX_VERTICES = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  psd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    psd_result_if.source  o_out
);
    import psd_pkg::*;

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int PW = $clog2(POLY_MAX_VERTICES);

    t_bstate     r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [8:0]  r_buf_x [POLY_MAX_VERTICES];
    logic [8:0]  r_buf_y [POLY_MAX_VERTICES];
    logic [8:0]  r_prev_x, r_prev_y, n_prev_x, n_prev_y;
    logic [3:0]  r_i, n_i, r_k, n_k;
    logic [VERTEX_DEPTH-1:0] r_vvalid;
    logic        r_rd_ok;

    logic        r_out_valid, n_out_valid;
    logic        out_load;
    logic [2:0]  r_kind, n_kind;
    logic [3:0]  r_col, n_col;
    logic [7:0]  r_red, r_green, r_blue, n_red, n_green, n_blue;
    logic [8:0]  r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [8:0]  n_ax, n_ay, n_bx, n_by, n_cx, n_cy;
    logic        r_last, n_last;

    logic        out_free, in_range, ram_we;
    logic [17:0] ram_rdata;
    logic        buf_we;
    logic [7:0]  buf_slot;
    logic [8:0]  buf_x, buf_y;
    logic [3:0]  third_idx, i_plus3;
    t_cmd        fan_cmd;
    logic [3:0]  fan_k;
    logic        fan_go;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_range = ({1'b0, i_cmd.addr} < 9'(VERTEX_DEPTH));
    assign o_pop = (r_state == BK_IDLE) && i_valid && out_free;
    assign ram_we = o_pop && (i_cmd.op == CMD_VWR) && in_range;
    assign third_idx = r_i + 4'd2;
    assign i_plus3 = r_i + 4'd3;

    psd_ram #(.WIDTH(18), .DEPTH(VERTEX_DEPTH)) u_vstore (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.addr[AW-1:0]),
        .i_wdata ({i_cmd.x, i_cmd.y}),
        .i_raddr (i_cmd.addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // The polygon that may start a fan is the popped one or the one waiting
    // on the vertex store read.
    assign fan_cmd = (r_state == BK_VREAD) ? r_cmd : i_cmd;
    assign fan_k = (fan_cmd.count < 4'(POLY_MAX_VERTICES)) ? fan_cmd.count
                                                            : 4'(POLY_MAX_VERTICES);
    assign fan_go = fan_cmd.poly_end && (fan_k >= 4'd3);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.op)
                        CMD_PAL:  n_state = i_cmd.clear_after ? BK_CLEAR : BK_IDLE;
                        CMD_PVTX: n_state = i_cmd.indexed ? BK_VREAD
                                          : (fan_go ? BK_FAN : BK_IDLE);
                        default:  n_state = BK_IDLE;
                    endcase
                end
            end
            BK_CLEAR: n_state = out_free ? BK_IDLE : BK_CLEAR;
            BK_VREAD: n_state = fan_go ? BK_FAN : BK_IDLE;
            BK_FAN:   n_state = (out_free && i_plus3 == r_k) ? BK_IDLE : BK_FAN;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = o_pop ? i_cmd : r_cmd;
        n_prev_x = r_prev_x;
        n_prev_y = r_prev_y;
        n_i = r_i;
        n_k = r_k;
        buf_we = 1'b0;
        buf_slot = fan_cmd.slot;
        buf_x = i_cmd.x;
        buf_y = i_cmd.y;
        out_load = 1'b0;
        n_kind = r_kind;
        n_col = r_col;
        n_red = '0;
        n_green = '0;
        n_blue = '0;
        n_ax = '0;
        n_ay = '0;
        n_bx = '0;
        n_by = '0;
        n_cx = '0;
        n_cy = '0;
        n_last = 1'b1;
        case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.op)
                        CMD_PAL: begin
                            out_load = 1'b1;
                            n_kind = KIND_PALETTE;
                            n_col = i_cmd.color;
                            n_red = times36(i_cmd.red);
                            n_green = times36(i_cmd.green);
                            n_blue = times36(i_cmd.blue);
                            n_last = !i_cmd.clear_after;
                        end
                        CMD_CLEAR: begin
                            out_load = 1'b1;
                            n_kind = KIND_CLEAR;
                            n_col = '0;
                        end
                        CMD_FEND: begin
                            out_load = 1'b1;
                            n_kind = KIND_FRAME_END;
                            n_col = '0;
                        end
                        CMD_SEND: begin
                            out_load = 1'b1;
                            n_kind = KIND_STREAM_END;
                            n_col = '0;
                        end
                        CMD_PVTX: buf_we = !i_cmd.indexed;
                        default: ;
                    endcase
                end
            end
            BK_CLEAR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_kind = KIND_CLEAR;
                    n_col = '0;
                end
            end
            BK_VREAD: begin
                buf_we = 1'b1;
                buf_x = r_rd_ok ? ram_rdata[17:9] : '0;
                buf_y = r_rd_ok ? ram_rdata[8:0] : '0;
            end
            BK_FAN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_kind = KIND_TRIANGLE;
                    n_col = r_cmd.color;
                    n_ax = r_buf_x[0];
                    n_ay = r_buf_y[0];
                    n_bx = r_prev_x;
                    n_by = r_prev_y;
                    n_cx = r_buf_x[third_idx[PW-1:0]];
                    n_cy = r_buf_y[third_idx[PW-1:0]];
                    n_last = (i_plus3 == r_k);
                    n_prev_x = n_cx;
                    n_prev_y = n_cy;
                    n_i = r_i + 4'd1;
                end
            end
            default: ;
        endcase
        if (r_state != BK_FAN && n_state == BK_FAN) begin
            n_i = '0;
            n_k = fan_k;
            n_prev_x = r_buf_x[1];
            n_prev_y = r_buf_y[1];
        end
        n_out_valid = out_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_vvalid <= '0;
            r_i <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_i <= n_i;
            r_k <= n_k;
            if (ram_we) r_vvalid[i_cmd.addr[AW-1:0]] <= 1'b1;
        end
        r_cmd <= n_cmd;
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
        r_rd_ok <= in_range && r_vvalid[i_cmd.addr[AW-1:0]];
        if (buf_we && buf_slot < 8'(POLY_MAX_VERTICES)) begin
            r_buf_x[buf_slot[PW-1:0]] <= buf_x;
            r_buf_y[buf_slot[PW-1:0]] <= buf_y;
        end
        if (out_load) begin
            r_kind <= n_kind;
            r_col <= n_col;
            r_red <= n_red;
            r_green <= n_green;
            r_blue <= n_blue;
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_bx <= n_bx;
            r_by <= n_by;
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_last <= n_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.kind = r_kind;
    assign o_out.color_index = r_col;
    assign o_out.red = r_red;
    assign o_out.green = r_green;
    assign o_out.blue = r_blue;
    assign o_out.ax = r_ax;
    assign o_out.ay = r_ay;
    assign o_out.bx = r_bx;
    assign o_out.by = r_by;
    assign o_out.cx = r_cx;
    assign o_out.cy = r_cy;
    assign o_out.last = r_last;

`ifndef NO_ASSERTIONS
    // A vertex store read always resolves in the following cycle.
    a_vread_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_VREAD |=> r_state != BK_VREAD) else $error("vertex read stuck");
    // A fan only runs for a polygon of at least three kept vertices.
    a_fan_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_FAN |-> (r_k >= 4'd3 && i_plus3 <= r_k)) else $error("bad fan");
    // A command is taken from the queue only when one is present.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid) else $error("pop from empty queue");
`endif
endmodule

[src/polygon_stream_decoder.sv]
// Polygon stream decoder: the parser accepts one stream byte per cycle while its
// four-entry command queue has room; the back end executes one command per cycle
// while its output is free; an indexed vertex waits on a registered read of the
// vertex store RAM, a palette word that also closes the palette with a clear is
// followed by a clear result, and the triangle fan of an n-vertex polygon emits
// n-2 triangles, one per beat. The vertex store is a RAM whose entries count as
// zero until written, tracked by one flag per entry; reset needs no clearing pass.
module polygon_stream_decoder #(
    parameter int VERTEX_DEPTH = 256,
    parameter int POLY_MAX_VERTICES = 15,
    parameter int SKIP_ALIGN_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psd_byte_if.sink     i_in,
    psd_result_if.source o_out
);
    import psd_pkg::*;

    logic full, push, pop, q_valid;
    t_cmd cmd_in, cmd_out;

    psd_front #(.SKIP_ALIGN_BITS(SKIP_ALIGN_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    psd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_out)
    );

    psd_back #(
        .VERTEX_DEPTH      (VERTEX_DEPTH),
        .POLY_MAX_VERTICES (POLY_MAX_VERTICES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
